>>> rtl/assert_macros.svh
// Assertion helpers shared by the rasterizer modules.
// Each macro expects the module to have signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define UVTRI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define UVTRI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/uvtri_pkg.sv
package uvtri_pkg;

   localparam int MAX_SIZE = 256;
   localparam int IDX_W    = $clog2(MAX_SIZE);
   localparam int SIZE_W   = IDX_W + 1;
   localparam int ADDR_W   = 2 * IDX_W;
   localparam int DEPTH    = MAX_SIZE * MAX_SIZE;

   localparam int MAP_W  = 9;
   localparam int UV_W   = 18;
   localparam int NRM_W  = 16;
   localparam int COL_W  = 8;
   localparam int RC_W   = 8;
   localparam int CNT_W  = 17;
   localparam int PIX_W  = 24;

   // Scaled corner coordinates, their differences and the edge values.
   localparam int CRD_W  = UV_W + IDX_W;
   localparam int DIF_W  = CRD_W + 1;
   localparam int PROD_W = 2 * DIF_W;
   localparam int E_W    = PROD_W + 2;
   localparam int FL_W   = CRD_W - 15;

   localparam int STEP_W = 4;

   // Setup sequencer steps.
   localparam logic [STEP_W-1:0] STEP_MUL_U1  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_MUL_V1  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_MUL_U2  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_MUL_V2  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_MUL_U3  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MUL_V3  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_ST_CY   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_BOX     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_ORIGIN  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_MUL_D1  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_MUL_D2  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_MUL_A1  = 4'd11;
   localparam logic [STEP_W-1:0] STEP_MUL_A2  = 4'd12;
   localparam logic [STEP_W-1:0] STEP_MUL_B1  = 4'd13;
   localparam logic [STEP_W-1:0] STEP_MUL_B2  = 4'd14;
   localparam logic [STEP_W-1:0] STEP_LAST    = 4'd15;

   localparam logic REQ_DRAW = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef struct packed {
      logic              clear;
      logic              load;
      logic              mem_read;
      logic              setup;
      logic [STEP_W-1:0] step;
      logic              init_scan;
      logic              scan;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic empty;
      logic scan_last;
   } status_type;

endpackage

>>> rtl/uvtri_ctrl.sv
`include "assert_macros.svh"

module uvtri_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_type,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output uvtri_pkg::cmd_type    cmd,
   input  uvtri_pkg::status_type status
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_SETUP = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_SCAN  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [uvtri_pkg::STEP_W-1:0] step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         accept, slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.step      = step_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = (req_type == uvtri_pkg::REQ_READ) ? ST_READ : ST_SETUP;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_DONE;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            step_in   = step_ff + 1'b1;
            if (step_ff == uvtri_pkg::STEP_LAST) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.init_scan = 1'b1;
            state_in      = status.empty ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `UVTRI_ASSERT_NEXT(a_clear_exit, state_ff == ST_CLEAR,
      (state_ff == ST_CLEAR) || (state_ff == ST_IDLE), "clear pass left to a bad state")
   `UVTRI_ASSERT_NEXT(a_no_instant_rsp, accept, !$rose(rsp_valid_ff),
      "result appeared in the cycle after a request was taken")

endmodule

>>> rtl/uvtri_dp.sv
`include "assert_macros.svh"

module uvtri_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  uvtri_pkg::cmd_type                  cmd,
   output uvtri_pkg::status_type               status,
   input  logic [uvtri_pkg::SIZE_W-1:0]        map_s,
   input  logic                                req_type,
   input  logic signed [uvtri_pkg::UV_W-1:0]   req_u_first,
   input  logic signed [uvtri_pkg::UV_W-1:0]   req_v_first,
   input  logic signed [uvtri_pkg::UV_W-1:0]   req_u_second,
   input  logic signed [uvtri_pkg::UV_W-1:0]   req_v_second,
   input  logic signed [uvtri_pkg::UV_W-1:0]   req_u_third,
   input  logic signed [uvtri_pkg::UV_W-1:0]   req_v_third,
   input  logic signed [uvtri_pkg::NRM_W-1:0]  req_normal_x,
   input  logic signed [uvtri_pkg::NRM_W-1:0]  req_normal_y,
   input  logic signed [uvtri_pkg::NRM_W-1:0]  req_normal_z,
   input  logic [uvtri_pkg::RC_W-1:0]          req_read_col,
   input  logic [uvtri_pkg::RC_W-1:0]          req_read_row,
   output logic [uvtri_pkg::COL_W-1:0]         rsp_red_out,
   output logic [uvtri_pkg::COL_W-1:0]         rsp_green_out,
   output logic [uvtri_pkg::COL_W-1:0]         rsp_blue_out,
   output logic [uvtri_pkg::CNT_W-1:0]         rsp_pixels_drawn
);

   localparam int UV_W   = uvtri_pkg::UV_W;
   localparam int CRD_W  = uvtri_pkg::CRD_W;
   localparam int DIF_W  = uvtri_pkg::DIF_W;
   localparam int PROD_W = uvtri_pkg::PROD_W;
   localparam int E_W    = uvtri_pkg::E_W;
   localparam int FL_W   = uvtri_pkg::FL_W;
   localparam int SIZE_W = uvtri_pkg::SIZE_W;
   localparam int IDX_W  = uvtri_pkg::IDX_W;
   localparam int ADDR_W = uvtri_pkg::ADDR_W;
   localparam int COL_W  = uvtri_pkg::COL_W;
   localparam int CNT_W  = uvtri_pkg::CNT_W;
   localparam int PIX_W  = uvtri_pkg::PIX_W;
   localparam int RC_W   = uvtri_pkg::RC_W;
   localparam int NRM_W  = uvtri_pkg::NRM_W;

   // Normal component to colour byte: saturate, bias, scale by 255/32768.
   function automatic logic [COL_W-1:0] colour_byte(input logic signed [NRM_W-1:0] n);
      logic [NRM_W-1:0] t;
      logic [NRM_W+7:0] p;
      if (n < -16'sd16384) begin
         t = '0;
      end else if (n > 16'sd16384) begin
         t = 16'd32768;
      end else begin
         t = NRM_W'(n + 16'sd16384);
      end
      p = {t, 8'd0} - (NRM_W+8)'(t);
      return p[22:15];
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_pix(input logic signed [FL_W-1:0] v,
                                                   input logic [SIZE_W-1:0]     s);
      logic signed [FL_W-1:0] sw;
      sw = FL_W'($signed({1'b0, s}));
      if (v < 0) begin
         return '0;
      end else if (v > sw) begin
         return s;
      end
      return v[SIZE_W-1:0];
   endfunction

   function automatic logic signed [CRD_W-1:0] min3(input logic signed [CRD_W-1:0] a,
                                                    input logic signed [CRD_W-1:0] b,
                                                    input logic signed [CRD_W-1:0] c);
      logic signed [CRD_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [CRD_W-1:0] max3(input logic signed [CRD_W-1:0] a,
                                                    input logic signed [CRD_W-1:0] b,
                                                    input logic signed [CRD_W-1:0] c);
      logic signed [CRD_W-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   // Request registers.
   logic                    type_ff;
   logic signed [UV_W-1:0]  u1_ff, v1_ff, u2_ff, v2_ff, u3_ff, v3_ff;
   logic [RC_W-1:0]         rcol_ff, rrow_ff;
   logic [PIX_W-1:0]        colour_ff;

   // Setup registers.
   logic signed [DIF_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [CRD_W-1:0]  ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [DIF_W-1:0]  a1_ff, b1_ff, a2_ff, b2_ff, dy_ff, gx_ff, gy_ff;
   logic [SIZE_W-1:0]        x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [E_W-1:0]    den_ff;
   logic signed [E_W-1:0]    sa_x_ff, sa_y_ff, sa_xy_ff;
   logic signed [E_W-1:0]    sb_x_ff, sb_y_ff, sb_xy_ff;
   logic signed [E_W-1:0]    sc_x_ff, sc_y_ff, sc_xy_ff;

   // Scan registers.
   logic signed [E_W-1:0]    na_ff, nb_ff, nc_ff, na_row_ff, nb_row_ff, nc_row_ff;
   logic [SIZE_W-1:0]        x_ff, y_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [ADDR_W-1:0]        clr_addr_ff;

   // Image store.
   logic [PIX_W-1:0]         mem [uvtri_pkg::DEPTH];
   logic [PIX_W-1:0]         rd_data_ff;
   logic                     mem_we;
   logic [ADDR_W-1:0]        waddr, raddr;
   logic [PIX_W-1:0]         wdata;

   logic signed [FL_W-1:0]   fx0, fy0, fx1, fy1;
   logic signed [DIF_W-1:0]  a1_w, b1_w, a2_w, b2_w;
   logic signed [E_W-1:0]    off_a [4];
   logic signed [E_W-1:0]    off_b [4];
   logic signed [E_W-1:0]    off_c [4];
   logic [3:0]               corner_in;
   logic                     hit, last_y, last_x, in_range;
   logic [SIZE_W-1:0]        row_w;

   // Bounding box corners from the scaled coordinates.
   always_comb begin
      logic signed [CRD_W:0] mxx, mxy;
      mxx = (CRD_W+1)'(max3(ax_ff, bx_ff, cx_ff)) + (CRD_W+1)'(65535);
      mxy = (CRD_W+1)'(max3(ay_ff, by_ff, cy_ff)) + (CRD_W+1)'(65535);
      fx0 = FL_W'(min3(ax_ff, bx_ff, cx_ff) >>> 16);
      fy0 = FL_W'(min3(ay_ff, by_ff, cy_ff) >>> 16);
      fx1 = FL_W'(mxx >>> 16);
      fy1 = FL_W'(mxy >>> 16);
   end

   assign a1_w = DIF_W'(by_ff) - DIF_W'(cy_ff);
   assign b1_w = DIF_W'(cx_ff) - DIF_W'(bx_ff);
   assign a2_w = DIF_W'(cy_ff) - DIF_W'(ay_ff);
   assign b2_w = DIF_W'(ax_ff) - DIF_W'(cx_ff);

   // Shared multiplier operand select.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         uvtri_pkg::STEP_MUL_U1: begin mul_a = DIF_W'(u1_ff); mul_b = DIF_W'(map_s); end
         uvtri_pkg::STEP_MUL_V1: begin mul_a = DIF_W'(v1_ff); mul_b = DIF_W'(map_s); end
         uvtri_pkg::STEP_MUL_U2: begin mul_a = DIF_W'(u2_ff); mul_b = DIF_W'(map_s); end
         uvtri_pkg::STEP_MUL_V2: begin mul_a = DIF_W'(v2_ff); mul_b = DIF_W'(map_s); end
         uvtri_pkg::STEP_MUL_U3: begin mul_a = DIF_W'(u3_ff); mul_b = DIF_W'(map_s); end
         uvtri_pkg::STEP_MUL_V3: begin mul_a = DIF_W'(v3_ff); mul_b = DIF_W'(map_s); end
         uvtri_pkg::STEP_MUL_D1: begin mul_a = a1_ff; mul_b = b2_ff; end
         uvtri_pkg::STEP_MUL_D2: begin mul_a = b1_ff; mul_b = dy_ff; end
         uvtri_pkg::STEP_MUL_A1: begin mul_a = a1_ff; mul_b = gx_ff; end
         uvtri_pkg::STEP_MUL_A2: begin mul_a = b1_ff; mul_b = gy_ff; end
         uvtri_pkg::STEP_MUL_B1: begin mul_a = a2_ff; mul_b = gx_ff; end
         uvtri_pkg::STEP_MUL_B2: begin mul_a = b2_ff; mul_b = gy_ff; end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Corner tests of edges a, b and c at the four corners of the current pixel.
   assign off_a[0] = na_ff;
   assign off_a[1] = na_ff + sa_x_ff;
   assign off_a[2] = na_ff + sa_y_ff;
   assign off_a[3] = na_ff + sa_xy_ff;
   assign off_b[0] = nb_ff;
   assign off_b[1] = nb_ff + sb_x_ff;
   assign off_b[2] = nb_ff + sb_y_ff;
   assign off_b[3] = nb_ff + sb_xy_ff;
   assign off_c[0] = nc_ff;
   assign off_c[1] = nc_ff + sc_x_ff;
   assign off_c[2] = nc_ff + sc_y_ff;
   assign off_c[3] = nc_ff + sc_xy_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         corner_in[k] = ((off_a[k] == 0) || (off_a[k][E_W-1] == den_ff[E_W-1]))
                     && ((off_b[k] == 0) || (off_b[k][E_W-1] == den_ff[E_W-1]))
                     && ((off_c[k] == 0) || (off_c[k][E_W-1] == den_ff[E_W-1]));
      end
   end

   assign hit    = |corner_in;
   assign last_y = (y_ff == y1_ff - 1'b1);
   assign last_x = (x_ff == x1_ff - 1'b1);
   assign row_w  = map_s - 1'b1 - y_ff;

   assign status.clear_last = (clr_addr_ff == ADDR_W'(uvtri_pkg::DEPTH - 1));
   assign status.empty      = (den_ff == 0) || (x0_ff >= x1_ff) || (y0_ff >= y1_ff);
   assign status.scan_last  = last_x && last_y;

   assign mem_we = cmd.clear || (cmd.scan && hit);
   assign waddr  = cmd.clear ? clr_addr_ff : {row_w[IDX_W-1:0], x_ff[IDX_W-1:0]};
   assign wdata  = cmd.clear ? '0 : colour_ff;
   assign raddr  = {IDX_W'(rrow_ff), IDX_W'(rcol_ff)};
   assign in_range = (32'(rcol_ff) < uvtri_pkg::MAX_SIZE)
                  && (32'(rrow_ff) < uvtri_pkg::MAX_SIZE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff   <= req_type;
         u1_ff     <= req_u_first;
         v1_ff     <= req_v_first;
         u2_ff     <= req_u_second;
         v2_ff     <= req_v_second;
         u3_ff     <= req_u_third;
         v3_ff     <= req_v_third;
         rcol_ff   <= req_read_col;
         rrow_ff   <= req_read_row;
         colour_ff <= {colour_byte(req_normal_x), colour_byte(req_normal_y),
                       colour_byte(req_normal_z)};
         count_ff  <= '0;
      end

      if (cmd.setup) begin
         prod_ff <= mul_a * mul_b;
         case (cmd.step)
            uvtri_pkg::STEP_MUL_V1: ax_ff <= CRD_W'(prod_ff);
            uvtri_pkg::STEP_MUL_U2: ay_ff <= CRD_W'(prod_ff);
            uvtri_pkg::STEP_MUL_V2: bx_ff <= CRD_W'(prod_ff);
            uvtri_pkg::STEP_MUL_U3: by_ff <= CRD_W'(prod_ff);
            uvtri_pkg::STEP_MUL_V3: cx_ff <= CRD_W'(prod_ff);
            uvtri_pkg::STEP_ST_CY:  cy_ff <= CRD_W'(prod_ff);
            uvtri_pkg::STEP_BOX: begin
               x0_ff <= clamp_pix(fx0, map_s);
               y0_ff <= clamp_pix(fy0, map_s);
               x1_ff <= clamp_pix(fx1, map_s);
               y1_ff <= clamp_pix(fy1, map_s);
               a1_ff <= a1_w;
               b1_ff <= b1_w;
               a2_ff <= a2_w;
               b2_ff <= b2_w;
               dy_ff <= DIF_W'(ay_ff) - DIF_W'(cy_ff);
            end
            uvtri_pkg::STEP_ORIGIN: begin
               gx_ff    <= DIF_W'({x0_ff, 16'd0}) - DIF_W'(cx_ff);
               gy_ff    <= DIF_W'({y0_ff, 16'd0}) - DIF_W'(cy_ff);
               sa_x_ff  <= E_W'(a1_ff) <<< 16;
               sa_y_ff  <= E_W'(b1_ff) <<< 16;
               sa_xy_ff <= (E_W'(a1_ff) + E_W'(b1_ff)) <<< 16;
               sb_x_ff  <= E_W'(a2_ff) <<< 16;
               sb_y_ff  <= E_W'(b2_ff) <<< 16;
               sb_xy_ff <= (E_W'(a2_ff) + E_W'(b2_ff)) <<< 16;
               sc_x_ff  <= -((E_W'(a1_ff) + E_W'(a2_ff)) <<< 16);
               sc_y_ff  <= -((E_W'(b1_ff) + E_W'(b2_ff)) <<< 16);
               sc_xy_ff <= -((E_W'(a1_ff) + E_W'(a2_ff) + E_W'(b1_ff) + E_W'(b2_ff)) <<< 16);
            end
            uvtri_pkg::STEP_MUL_D2: den_ff <= E_W'(prod_ff);
            uvtri_pkg::STEP_MUL_A1: den_ff <= den_ff + E_W'(prod_ff);
            uvtri_pkg::STEP_MUL_A2: na_ff  <= E_W'(prod_ff);
            uvtri_pkg::STEP_MUL_B1: na_ff  <= na_ff + E_W'(prod_ff);
            uvtri_pkg::STEP_MUL_B2: nb_ff  <= E_W'(prod_ff);
            uvtri_pkg::STEP_LAST:   nb_ff  <= nb_ff + E_W'(prod_ff);
            default: begin
            end
         endcase
      end

      if (cmd.init_scan) begin
         x_ff      <= x0_ff;
         y_ff      <= y0_ff;
         na_row_ff <= na_ff;
         nb_row_ff <= nb_ff;
         nc_ff     <= den_ff - na_ff - nb_ff;
         nc_row_ff <= den_ff - na_ff - nb_ff;
      end

      if (cmd.scan) begin
         if (hit) begin
            count_ff <= count_ff + 1'b1;
         end
         if (last_y) begin
            y_ff      <= y0_ff;
            x_ff      <= x_ff + 1'b1;
            na_row_ff <= na_row_ff + sa_x_ff;
            nb_row_ff <= nb_row_ff + sb_x_ff;
            nc_row_ff <= nc_row_ff + sc_x_ff;
            na_ff     <= na_row_ff + sa_x_ff;
            nb_ff     <= nb_row_ff + sb_x_ff;
            nc_ff     <= nc_row_ff + sc_x_ff;
         end else begin
            y_ff  <= y_ff + 1'b1;
            na_ff <= na_ff + sa_y_ff;
            nb_ff <= nb_ff + sb_y_ff;
            nc_ff <= nc_ff + sc_y_ff;
         end
      end

      if (cmd.out_load) begin
         if (type_ff == uvtri_pkg::REQ_READ) begin
            rsp_red_out      <= in_range ? rd_data_ff[23:16] : '0;
            rsp_green_out    <= in_range ? rd_data_ff[15:8]  : '0;
            rsp_blue_out     <= in_range ? rd_data_ff[7:0]   : '0;
            rsp_pixels_drawn <= '0;
         end else begin
            rsp_red_out      <= '0;
            rsp_green_out    <= '0;
            rsp_blue_out     <= '0;
            rsp_pixels_drawn <= count_ff;
         end
      end
   end

   `UVTRI_ASSERT(a_scan_in_box, cmd.scan |-> ((x_ff < x1_ff) && (y_ff < y1_ff)),
      "scan position left the bounding box")

endmodule

>>> rtl/uv_triangle_normal_rasterizer.sv
// Channel   Direction  Handshake              Content
// req_*     in         req_valid / req_stall  one draw or read request per beat
// rsp_*     out        rsp_valid / rsp_stall  one result per request
// psel etc  in         APB, pready always 1   map_size register at byte address 0
//
// A draw runs the setup steps and then scans the pixels of its clamped bounding box:
// the setup runs all products through one shared 27x27 multiplier, and the scan
// visits one pixel per cycle. A read goes through the store's registered read port.
// After reset the image store is zeroed one word per cycle, all 65536 words, and no
// request beat is taken until that pass ends; register writes are taken throughout.
// A finished result waits in the output register while the next request is taken.
module uv_triangle_normal_rasterizer (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic signed [uvtri_pkg::UV_W-1:0]   req_u_first,
   input  logic signed [uvtri_pkg::UV_W-1:0]   req_v_first,
   input  logic signed [uvtri_pkg::UV_W-1:0]   req_u_second,
   input  logic signed [uvtri_pkg::UV_W-1:0]   req_v_second,
   input  logic signed [uvtri_pkg::UV_W-1:0]   req_u_third,
   input  logic signed [uvtri_pkg::UV_W-1:0]   req_v_third,
   input  logic signed [uvtri_pkg::NRM_W-1:0]  req_normal_x,
   input  logic signed [uvtri_pkg::NRM_W-1:0]  req_normal_y,
   input  logic signed [uvtri_pkg::NRM_W-1:0]  req_normal_z,
   input  logic [uvtri_pkg::RC_W-1:0]          req_read_col,
   input  logic [uvtri_pkg::RC_W-1:0]          req_read_row,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [uvtri_pkg::COL_W-1:0]         rsp_red_out,
   output logic [uvtri_pkg::COL_W-1:0]         rsp_green_out,
   output logic [uvtri_pkg::COL_W-1:0]         rsp_blue_out,
   output logic [uvtri_pkg::CNT_W-1:0]         rsp_pixels_drawn,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   uvtri_pkg::cmd_type               cmd;
   uvtri_pkg::status_type            status;
   logic [uvtri_pkg::MAP_W-1:0]      map_size_ff, map_size_in;
   logic [uvtri_pkg::SIZE_W-1:0]     map_s;
   logic                             reg_hit;

   // The only register sits at byte address 0; address 4 and up fall outside it.
   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == 1'b0);
   assign prdata  = reg_hit ? 32'(map_size_ff) : '0;

   always_comb begin
      map_size_in = map_size_ff;
      if (psel && penable && pwrite && reg_hit) begin
         map_size_in = pwdata[uvtri_pkg::MAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff <= uvtri_pkg::MAP_W'(256);
      end else begin
         map_size_ff <= map_size_in;
      end
   end

   // The map edge in use is the register saturated to one through the store's edge.
   always_comb begin
      if (map_size_ff == '0) begin
         map_s = uvtri_pkg::SIZE_W'(1);
      end else if (32'(map_size_ff) > uvtri_pkg::MAX_SIZE) begin
         map_s = uvtri_pkg::SIZE_W'(uvtri_pkg::MAX_SIZE);
      end else begin
         map_s = uvtri_pkg::SIZE_W'(map_size_ff);
      end
   end

   // The controller sequences clearing, reads, setup, scan and the result beat.
   uvtri_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the request, the shared multiplier, the edge
   // functions, the image store and the result payload.
   uvtri_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .map_s            (map_s),
      .req_type         (req_type),
      .req_u_first      (req_u_first),
      .req_v_first      (req_v_first),
      .req_u_second     (req_u_second),
      .req_v_second     (req_v_second),
      .req_u_third      (req_u_third),
      .req_v_third      (req_v_third),
      .req_normal_x     (req_normal_x),
      .req_normal_y     (req_normal_y),
      .req_normal_z     (req_normal_z),
      .req_read_col     (req_read_col),
      .req_read_row     (req_read_row),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_pixels_drawn (rsp_pixels_drawn)
   );

endmodule
